### hw/rtl/lzwe_pkg.sv
`timescale 1ns / 1ps
package lzwe_pkg;

  // Default geometry: 12-bit codes, 8192 hash slots (a power of two).
  localparam int DEF_CODE_BITS  = 12;
  localparam int DEF_HASH_SLOTS = 8192;

  // Codes 0 to 255 stand for the single bytes; the first added entry is 256.
  localparam int SINGLE_CODES = 256;
  localparam int BYTE_W       = 8;

  // The entry limit register.
  localparam int                    ENTRY_LIMIT_W     = 13;
  localparam logic [ENTRY_LIMIT_W-1:0] ENTRY_LIMIT_RESET = 13'd4095;

  // Multiplicative hash: key * golden-ratio constant, then XOR in the product shifted right by HASH_SHIFT.
  localparam int          HASH_W     = 32;
  localparam logic [31:0] HASH_MULT  = 32'd2654435761;
  localparam int          HASH_SHIFT = 15;

endpackage

### hw/rtl/lzwe_byte_if.sv
`timescale 1ns / 1ps
interface lzwe_byte_if import lzwe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

### hw/rtl/lzwe_code_if.sv
`timescale 1ns / 1ps
interface lzwe_code_if import lzwe_pkg::*; #(
  parameter int CODE_BITS = DEF_CODE_BITS
) ();
  logic                 valid;
  logic                 ready;
  logic [CODE_BITS-1:0] code;
  logic                 last_code;

  modport source (output valid, code, last_code, input ready);
  modport sink   (input valid, code, last_code, output ready);
endinterface

### hw/rtl/lzwe_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM: one write port, one read port with registered data.
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lzwe_hash.sv
`timescale 1ns / 1ps
// Home slot of a dictionary key. The product is registered, so the slot
// address is valid in the cycle after the key.
module lzwe_hash import lzwe_pkg::*; #(
  parameter int CODE_BITS  = DEF_CODE_BITS,
  parameter int HASH_SLOTS = DEF_HASH_SLOTS,
  localparam int KEY_W = CODE_BITS + BYTE_W,
  localparam int AW    = $clog2(HASH_SLOTS)
) (
  input  logic             clk,
  input  logic [KEY_W-1:0] key,
  output logic [AW-1:0]    slot
);

  logic [HASH_W-1:0] product;
  logic [HASH_W-1:0] folded;

  always_ff @(posedge clk) begin
    product <= HASH_W'(HASH_W'(key) * HASH_MULT);
  end

  assign folded = product ^ (product >> HASH_SHIFT);
  assign slot   = folded[AW-1:0];

endmodule

### hw/rtl/lzwe_out_fifo.sv
`timescale 1ns / 1ps
// Two-entry result queue that decouples the sequencer from the code sink.
module lzwe_out_fifo #(
  parameter int WIDTH = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             space,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             pop;

  assign space     = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = slots[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### hw/rtl/lzw_byte_encoder.sv
`timescale 1ns / 1ps
// The first byte of a text only becomes the prefix; every later byte goes through S_HASH,
// S_READ and S_CHECK, then S_EMIT when it emits a code, with S_CHECK again for each extra probe step.
// A new byte is taken only in S_IDLE, after the last one is through the hash-multiply, RAM read and
// compare steps of the dictionary lookup. The end-of-input byte adds an S_FLUSH step and
// then a clearing pass over all HASH_SLOTS slots. Reset (rst, synchronous) sets entry_limit to
// 4095 and starts the same clearing pass; no byte is taken during it.
module lzw_byte_encoder import lzwe_pkg::*; #(
  parameter int HASH_SLOTS = DEF_HASH_SLOTS,
  parameter int CODE_BITS  = DEF_CODE_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  lzwe_byte_if.sink                bytes,
  lzwe_code_if.source              codes,
  input  logic                     cfg_we,
  input  logic [ENTRY_LIMIT_W-1:0] cfg_wdata
);

  // The dictionary is one RAM of HASH_SLOTS slots, addressed by a multiplicative hash
  // of the key {prefix code, byte} and searched by linear probing. Each slot holds a used
  // flag, the full key and the code given to it. HASH_SLOTS must be a power of two.
  localparam int AW      = $clog2(HASH_SLOTS);
  localparam int KEY_W   = CODE_BITS + BYTE_W;
  localparam int SLOT_W  = 1 + KEY_W + CODE_BITS;
  localparam int NEXT_W  = CODE_BITS + 1;
  localparam int CMP_W   = (NEXT_W > ENTRY_LIMIT_W) ? NEXT_W : ENTRY_LIMIT_W;
  localparam int OUT_W   = CODE_BITS + 1;
  localparam int CODE_SPACE = 1 << CODE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;  // sweep every slot to empty
  localparam logic [2:0] S_IDLE  = 3'd1;  // wait for a byte
  localparam logic [2:0] S_HASH  = 3'd2;  // multiply stage of the hash
  localparam logic [2:0] S_READ  = 3'd3;  // read the home slot
  localparam logic [2:0] S_CHECK = 3'd4;  // compare a slot, step on to the next if needed
  localparam logic [2:0] S_EMIT  = 3'd5;  // emit the prefix code and insert the new entry if allowed
  localparam logic [2:0] S_FLUSH = 3'd6;  // emit the final code of the text

  logic [2:0]               state;
  logic [ENTRY_LIMIT_W-1:0] entry_limit;
  logic [CODE_BITS-1:0]     prefix_code;
  logic                     prefix_valid;
  logic [NEXT_W-1:0]        next_code;
  logic [AW-1:0]            clear_addr;
  logic [AW-1:0]            probe_addr;
  logic [AW:0]              probe_count;
  logic                     slot_free;

  // Item under work.
  logic [BYTE_W-1:0]        cur_byte;
  logic                     cur_last;
  logic [KEY_W-1:0]         cur_key;

  logic                     accept;
  logic [AW-1:0]            home_slot;
  logic [AW-1:0]            probe_step;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [SLOT_W-1:0]        ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [SLOT_W-1:0]        ram_rdata;

  logic                     slot_used;
  logic [KEY_W-1:0]         slot_key;
  logic [CODE_BITS-1:0]     slot_code;
  logic                     slot_hit;

  logic [CMP_W-1:0]         limit_ext;
  logic [CMP_W-1:0]         limit_eff;
  logic                     can_add;

  logic                     q_push;
  logic [OUT_W-1:0]         q_data;
  logic                     q_space;
  logic [OUT_W-1:0]         q_out;

  // A byte is taken only between items, never during a clearing pass.
  assign bytes.ready = (state == S_IDLE);
  assign accept      = bytes.valid && bytes.ready;

  // The entry limit is clamped to the code space; a limit of 256 or less adds nothing.
  assign limit_ext = CMP_W'(entry_limit);
  assign limit_eff = (limit_ext > CMP_W'(CODE_SPACE)) ? CMP_W'(CODE_SPACE) : limit_ext;
  assign can_add   = CMP_W'(next_code) < limit_eff;

  // Fields of the slot read in the previous cycle.
  assign slot_used = ram_rdata[SLOT_W-1];
  assign slot_key  = ram_rdata[SLOT_W-2 -: KEY_W];
  assign slot_code = ram_rdata[CODE_BITS-1:0];
  assign slot_hit  = slot_used && (slot_key == cur_key);

  assign probe_step = probe_addr + AW'(1);

  lzwe_hash #(
    .CODE_BITS  (CODE_BITS),
    .HASH_SLOTS (HASH_SLOTS)
  ) u_hash (
    .clk  (clk),
    .key  (cur_key),
    .slot (home_slot)
  );

  // Read address: the home slot right after the hash, else the next slot of the probe.
  assign ram_raddr = (state == S_READ) ? home_slot : probe_step;

  // Writes come from the clearing pass or from an insert. The insert is written in S_EMIT
  // and the next lookup cannot read before S_READ of a later item, so a read never meets a
  // write to the same slot in flight; the sequence itself is the interlock.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clear_addr;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if ((state == S_EMIT) && q_space && can_add && slot_free) begin
      ram_we    = 1'b1;
      ram_waddr = probe_addr;
      ram_wdata = {1'b1, cur_key, next_code[CODE_BITS-1:0]};
    end
  end

  lzwe_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (HASH_SLOTS)
  ) u_dict (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Results go into the queue: the prefix code on a miss, the final code on a flush.
  always_comb begin
    q_push = 1'b0;
    q_data = {prefix_code, 1'b0};
    if ((state == S_EMIT) && q_space) begin
      q_push = 1'b1;
    end else if ((state == S_FLUSH) && q_space) begin
      q_push = 1'b1;
      q_data = {prefix_code, 1'b1};
    end
  end

  lzwe_out_fifo #(
    .WIDTH (OUT_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .space     (q_space),
    .pop_valid (codes.valid),
    .pop_ready (codes.ready),
    .pop_data  (q_out)
  );

  assign codes.code      = q_out[OUT_W-1:1];
  assign codes.last_code = q_out[0];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= ENTRY_LIMIT_RESET;
    end else if (cfg_we) begin
      entry_limit <= cfg_wdata;
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= bytes.data_byte;
      cur_last <= bytes.end_of_input;
      cur_key  <= {prefix_code, bytes.data_byte};
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clear_addr   <= '0;
      prefix_code  <= '0;
      prefix_valid <= 1'b0;
      next_code    <= NEXT_W'(SINGLE_CODES);
      probe_addr   <= '0;
      probe_count  <= '0;
      slot_free    <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + AW'(1);
          if (clear_addr == AW'(HASH_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            if (!prefix_valid) begin
              // The first byte of a text only becomes the prefix.
              prefix_code  <= CODE_BITS'(bytes.data_byte);
              prefix_valid <= 1'b1;
              state        <= bytes.end_of_input ? S_FLUSH : S_IDLE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        S_HASH: begin
          state <= S_READ;
        end
        S_READ: begin
          probe_addr  <= home_slot;
          probe_count <= '0;
          state       <= S_CHECK;
        end
        S_CHECK: begin
          if (slot_hit) begin
            // The longer string is known: it becomes the prefix.
            prefix_code <= slot_code;
            state       <= cur_last ? S_FLUSH : S_IDLE;
          end else if (!slot_used) begin
            slot_free <= 1'b1;
            state     <= S_EMIT;
          end else if (probe_count == (AW + 1)'(HASH_SLOTS - 1)) begin
            // Every slot was looked at without a free one: nothing will be inserted.
            slot_free <= 1'b0;
            state     <= S_EMIT;
          end else begin
            probe_addr  <= probe_step;
            probe_count <= probe_count + (AW + 1)'(1);
          end
        end
        S_EMIT: begin
          if (q_space) begin
            if (can_add) begin
              next_code <= next_code + NEXT_W'(1);
            end
            prefix_code <= CODE_BITS'(cur_byte);
            state       <= cur_last ? S_FLUSH : S_IDLE;
          end
        end
        S_FLUSH: begin
          if (q_space) begin
            // End of text: the dictionary and the prefix start over.
            prefix_code  <= '0;
            prefix_valid <= 1'b0;
            next_code    <= NEXT_W'(SINGLE_CODES);
            clear_addr   <= '0;
            state        <= S_CLEAR;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // The next code never passes the size of the code space.
  a_next_code_bound: assert property (@(posedge clk) disable iff (rst)
    next_code <= NEXT_W'(CODE_SPACE))
    else $error("next_code beyond the code space");

  // A result is queued only when the queue has room.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_space)
    else $error("result queued into a full queue");

  // A finished flush always starts a clearing pass with no prefix held.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) && q_space |=> (state == S_CLEAR) && !prefix_valid
      && (clear_addr == '0))
    else $error("flush did not start a clearing pass");

  // No byte is taken while the dictionary is being cleared, and the RAM write enable stays high.
  a_no_take_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !accept && ram_we)
    else $error("byte taken or slot left unwritten during the clearing pass");

endmodule
